// ===== sv/sce_pkg.sv =====
// Package: constants, types and helpers shared by the spline curve evaluator.
package sce_pkg;

  localparam int MaxKnots  = 256;
  localparam int IdxW      = 8;
  localparam int CntW      = 9;
  localparam int AddrW     = 5;
  localparam int OneQ      = 65536;

  localparam logic [AddrW-1:0] RegKind   = 5'd0;
  localparam logic [AddrW-1:0] RegRot    = 5'd4;
  localparam logic [AddrW-1:0] RegDegree = 5'd8;
  localparam logic [AddrW-1:0] RegFix    = 5'd12;
  localparam logic [AddrW-1:0] RegCount  = 5'd16;

  localparam logic [1:0] KindIdentity = 2'd0;
  localparam logic [1:0] KindConst    = 2'd1;
  localparam logic [1:0] KindStep     = 2'd2;
  localparam logic [1:0] KindInterp   = 2'd3;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic       rot;
    logic [3:0] degree;
    logic       fix;
    logic [CntW-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic [7:0]         slot;
    logic signed [31:0] time_value;
    logic signed [31:0] comp_a;
    logic signed [31:0] comp_b;
    logic signed [31:0] comp_c;
    logic signed [31:0] comp_d;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_a;
    logic signed [31:0] out_b;
    logic signed [31:0] out_c;
    logic signed [31:0] out_d;
    logic               from_default;
    logic               is_query;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

// ===== sv/sce_if.sv =====
// Valid/ready channel interfaces for input and result beats.
interface sce_in_if (input logic clk);
  logic                 valid;
  logic                 ready;
  sce_pkg::in_item_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sce_out_if (input logic clk);
  logic                 valid;
  logic                 ready;
  sce_pkg::out_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sce_div.sv =====
// Shared restoring divider: unsigned 64/64 quotient, one bit per cycle.
module sce_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           num,
  input  logic [63:0]           den,
  output logic                  busy,
  output logic [63:0]           quo
);
  import sce_pkg::*;

  logic [63:0] rem_r, rem_nxt, q_r, q_nxt, d_r, d_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[63]} - {1'b0, d_r};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num;
      d_nxt    = den;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], q_r[63]};
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end

  assign busy = busy_r | start;
  assign quo  = q_r;

  always_ff @(posedge clk) begin
    if (rst_n && busy_r && !start) begin
      assert (cnt_r != 7'd0) else $error("divider running with zero count");
    end
  end
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 7'd64)
    else $error("divider count out of range");
  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && cnt_r == 7'd64) else $error("divider start not taken");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start && cnt_r == 7'd1 |=> !busy_r) else $error("divider overran");
endmodule

// ===== sv/sce_core.sv =====
// Sequencer: table storage, knot scan, weights, blend, sign fix and normalise.
module sce_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sce_pkg::cfg_t        cfg,
  sce_in_if.sink               in_ch,
  sce_out_if.source            out_ch
);
  import sce_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001, S_SCAN  = 16'h0002, S_SCANW = 16'h0004, S_WIN = 16'h0008,
    S_WINW  = 16'h0010, S_FIX   = 16'h0020, S_DIV   = 16'h0040, S_DIVW = 16'h0080,
    S_MUL   = 16'h0100, S_BLEND = 16'h0200, S_NSUM  = 16'h0400, S_SQRT = 16'h0800,
    S_NDIV  = 16'h1000, S_NDIVW = 16'h2000, S_OUT   = 16'h4000, S_RD  = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] knot_mem [MaxKnots];
  logic [127:0]       pt_mem   [MaxKnots];
  logic signed [31:0] kd_r;
  logic [127:0]       pd_r;
  logic [IdxW-1:0]    ra_r, ra_nxt;

  in_item_t           it_r, it_nxt;
  out_item_t          res_r, res_nxt;
  logic [CntW-1:0]    n_r, n_nxt;
  logic [CntW-1:0]    idx_r, idx_nxt;
  logic [2:0]         k_r, k_nxt;
  logic signed [31:0] kn_r [4];
  logic signed [31:0] kn_nxt [4];
  logic signed [31:0] pt_r [3][4];
  logic signed [31:0] pt_nxt [3][4];
  logic signed [31:0] w_r [3];
  logic signed [31:0] w_nxt [3];
  logic signed [31:0] q_r [4];
  logic signed [31:0] q_nxt [4];
  logic               clamp_r, clamp_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [63:0]        root_r, root_nxt, bit_r, bit_nxt, x_r, x_nxt;
  logic [5:0]         sh_r, sh_nxt;

  logic        dstart;
  logic [63:0] dnum, dden, dquo;
  logic        dbusy;

  sce_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(dden),
                 .busy(dbusy), .quo(dquo));

  logic signed [CntW+1:0] start_s, j_s;
  logic signed [65:0] num_s, den_s, prod_s, tmp_s;
  logic signed [31:0] ua, ub;
  logic [31:0]        mag;
  logic [63:0]        sq, nn;
  logic [CntW-1:0]    n_clip;

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid && in_ch.data.func == FuncLoad) begin
      knot_mem[in_ch.data.slot] <= in_ch.data.time_value;
      pt_mem[in_ch.data.slot]   <= {in_ch.data.comp_d, in_ch.data.comp_c,
                                    in_ch.data.comp_b, in_ch.data.comp_a};
    end
    kd_r <= knot_mem[ra_nxt];
    pd_r <= pt_mem[ra_nxt];
  end

  function automatic logic signed [31:0] ngs(input logic signed [31:0] x);
    return (x == 32'sh80000000) ? 32'sh7fffffff : -x;
  endfunction

  always_comb begin
    state_nxt = state_r; it_nxt = it_r; res_nxt = res_r; n_nxt = n_r;
    idx_nxt = idx_r; k_nxt = k_r; kn_nxt = kn_r; pt_nxt = pt_r; w_nxt = w_r;
    q_nxt = q_r; clamp_nxt = clamp_r; acc_nxt = acc_r; ra_nxt = ra_r;
    root_nxt = root_r; bit_nxt = bit_r; x_nxt = x_r; sh_nxt = sh_r;
    dstart = 1'b0; dnum = '0; dden = '0;
    n_clip = (cfg.count > CntW'(MaxKnots)) ? CntW'(MaxKnots) : cfg.count;
    start_s = $signed({2'b0, idx_r}) - $signed({7'b0, cfg.degree});
    j_s = start_s + $signed({8'b0, k_r});
    if (j_s < 0) j_s = '0;
    if (j_s > $signed({2'b0, n_r}) - 11'sd1) j_s = $signed({2'b0, n_r}) - 11'sd1;
    num_s = '0; den_s = '0; prod_s = '0; tmp_s = '0; ua = '0; ub = '0;
    mag = '0; sq = '0; nn = '0;
    in_ch.ready = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        ra_nxt = '0;
        if (in_ch.valid) begin
          it_nxt = in_ch.data;
          n_nxt = n_clip;
          res_nxt = '0;
          idx_nxt = '0;
          if (in_ch.data.func == FuncLoad) state_nxt = S_OUT;
          else if (cfg.kind == KindIdentity || (cfg.kind != KindConst && n_clip == '0)) begin
            res_nxt = {in_ch.data.comp_a, in_ch.data.comp_b, in_ch.data.comp_c,
                       in_ch.data.comp_d, 1'b1, 1'b1};
            state_nxt = S_OUT;
          end else state_nxt = S_SCANW;
        end
      end
      S_SCANW: state_nxt = S_SCAN;
      S_SCAN: begin
        // read data for ra_r is in kd_r/pd_r
        if (cfg.kind == KindConst) begin
          res_nxt.is_query = 1'b1;
          if (cfg.rot) begin
            res_nxt.out_a = pd_r[127:96]; res_nxt.out_b = pd_r[31:0];
            res_nxt.out_c = pd_r[63:32];  res_nxt.out_d = pd_r[95:64];
          end else begin
            res_nxt.out_a = pd_r[31:0];  res_nxt.out_b = pd_r[63:32];
            res_nxt.out_c = pd_r[95:64]; res_nxt.out_d = pd_r[127:96];
          end
          state_nxt = S_OUT;
        end else if (kd_r <= it_r.time_value && idx_r < n_r - 9'd1) begin
          idx_nxt = idx_r + 9'd1;
          ra_nxt = IdxW'(idx_r + 9'd1);
          state_nxt = S_SCANW;
        end else begin
          if (kd_r <= it_r.time_value) idx_nxt = idx_r; // clamp to last
          res_nxt.is_query = 1'b1;
          if (cfg.kind == KindStep && !cfg.rot) begin
            res_nxt.out_a = pd_r[31:0];  res_nxt.out_b = pd_r[63:32];
            res_nxt.out_c = pd_r[95:64]; res_nxt.out_d = pd_r[127:96];
            state_nxt = S_OUT;
          end else begin
            k_nxt = '0;
            clamp_nxt = (start_s < 0) ||
                        ({1'b0, idx_r} + {6'b0, cfg.degree} > {1'b0, n_r});
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        ra_nxt = IdxW'(j_s);
        state_nxt = S_WINW;
      end
      S_WINW: state_nxt = S_WIN;
      S_WIN: begin
        kn_nxt[k_r[1:0]] = kd_r;
        if (k_r < 3'd3) begin
          pt_nxt[k_r[1:0]][0] = pd_r[31:0];  pt_nxt[k_r[1:0]][1] = pd_r[63:32];
          pt_nxt[k_r[1:0]][2] = pd_r[95:64]; pt_nxt[k_r[1:0]][3] = pd_r[127:96];
        end
        if (k_r == 3'd3) begin
          k_nxt = '0;
          state_nxt = (cfg.rot && clamp_r && cfg.fix) ? S_FIX : S_DIV;
        end else begin
          k_nxt = k_r + 3'd1;
          state_nxt = S_RD;
        end
      end
      S_FIX: begin
        // dot of point k with previous point; point 0 has zero prev
        if (k_r != 3'd0) begin
          tmp_s = '0;
          for (int c = 0; c < 4; c++)
            tmp_s = tmp_s + 66'(pt_r[k_r[1:0]][c] * pt_r[k_r[1:0]-2'd1][c]);
          if (tmp_s < 0)
            for (int c = 0; c < 4; c++) pt_nxt[k_r[1:0]][c] = ngs(pt_r[k_r[1:0]][c]);
        end
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd2) begin k_nxt = '0; state_nxt = S_DIV; end
      end
      S_DIV: begin
        case (k_r)
          3'd0: begin num_s = it_r.time_value - kn_r[0]; den_s = kn_r[2] - kn_r[0]; end
          3'd1: begin num_s = it_r.time_value - kn_r[1]; den_s = kn_r[2] - kn_r[1]; end
          default: begin num_s = it_r.time_value - kn_r[1]; den_s = kn_r[3] - kn_r[1]; end
        endcase
        acc_nxt = {63'b0, num_s[65] ^ den_s[65]};
        if (den_s == 0) begin
          w_nxt[k_r[1:0]] = '0;
          state_nxt = (k_r == 3'd2) ? S_MUL : S_DIV;
          k_nxt = (k_r == 3'd2) ? 3'd0 : k_r + 3'd1;
        end else begin
          dstart = 1'b1;
          dnum = 64'((num_s[65] ? -num_s : num_s) <<< 16);
          dden = 64'(den_s[65] ? -den_s : den_s);
          state_nxt = S_DIVW;
        end
      end
      S_DIVW: if (!dbusy) begin
        tmp_s = acc_r[0] ? -$signed({2'b0, dquo}) : $signed({2'b0, dquo});
        w_nxt[k_r[1:0]] = sat32(tmp_s);
        state_nxt = (k_r == 3'd2) ? S_MUL : S_DIV;
        k_nxt = (k_r == 3'd2) ? 3'd0 : k_r + 3'd1;
      end
      S_MUL: begin
        // w_r holds u,v,s; one product per cycle
        case (k_r)
          3'd0: begin
            prod_s = 66'(w_r[0] * w_r[1]) + 66'sd32768;
            tmp_s = 66'(w_r[0]) + 66'(w_r[1]) - (prod_s >>> 16);
            w_nxt[0] = sat32(tmp_s); // b
          end
          3'd1: begin
            prod_s = 66'(w_r[2] * w_r[1]) + 66'sd32768;
            w_nxt[2] = sat32(prod_s >>> 16); // w2
          end
          default: begin
            w_nxt[1] = sat32(66'(w_r[0]) - 66'(w_r[2]));
            w_nxt[0] = sat32(66'sd65536 - 66'(w_r[0]));
          end
        endcase
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd2) begin k_nxt = '0; acc_nxt = 64'd32768; state_nxt = S_BLEND; end
      end
      S_BLEND: begin
        // component c = k_r[1:0]; sum three products exactly
        tmp_s = 66'sd32768;
        for (int i = 0; i < 3; i++) tmp_s = tmp_s + 66'(pt_r[i][k_r[1:0]] * w_r[i]);
        q_nxt[k_r[1:0]] = sat32(tmp_s >>> 16);
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd3) begin
          k_nxt = '0;
          if (cfg.rot) begin
            q_nxt[0] = sat32(tmp_s >>> 16); // w
            q_nxt[1] = q_r[0]; q_nxt[2] = q_r[1]; q_nxt[3] = q_r[2];
            acc_nxt = '0;
            state_nxt = S_NSUM;
          end else begin
            res_nxt.out_a = q_r[0]; res_nxt.out_b = q_r[1]; res_nxt.out_c = q_r[2];
            res_nxt.out_d = sat32(tmp_s >>> 16);
            state_nxt = S_OUT;
          end
        end
      end
      S_NSUM: begin
        if (k_r == 3'd0 && q_r[0] == 32'sh80000000 && q_r[1] == q_r[0] &&
            q_r[2] == q_r[0] && q_r[3] == q_r[0]) begin
          for (int c = 0; c < 4; c++) q_nxt[c] = -32'sd1;
          mag = 32'd1;
        end else mag = q_r[k_r[1:0]][31] ? 32'(-q_r[k_r[1:0]]) : 32'(q_r[k_r[1:0]]);
        acc_nxt = acc_r + 64'(mag) * 64'(mag);
        k_nxt = k_r + 3'd1;
        if (k_r == 3'd3) begin
          k_nxt = '0;
          sq = acc_nxt; sh_nxt = '0;
          if (sq == '0) begin
            res_nxt.out_a = '0; res_nxt.out_b = '0; res_nxt.out_c = '0; res_nxt.out_d = '0;
            state_nxt = S_OUT;
          end else begin
            x_nxt = sq; root_nxt = '0; bit_nxt = 64'h4000_0000_0000_0000;
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        // shift up to >= 2^60 before the first root step, then one root step per cycle
        if (bit_r == 64'h4000_0000_0000_0000 && x_r < 64'h1000_0000_0000_0000) begin
          x_nxt = x_r << 2; sh_nxt = sh_r + 6'd1;
        end else if (bit_r != '0) begin
          if (x_r >= root_r + bit_r) begin
            x_nxt = x_r - (root_r + bit_r);
            root_nxt = (root_r >> 1) + bit_r;
          end else root_nxt = root_r >> 1;
          bit_nxt = bit_r >> 2;
        end else state_nxt = S_NDIV;
      end
      S_NDIV: begin
        mag = q_r[k_r[1:0]][31] ? 32'(-q_r[k_r[1:0]]) : 32'(q_r[k_r[1:0]]);
        nn = ((64'(mag) << sh_r) << 16) + (root_r >> 1);
        dstart = 1'b1; dnum = nn; dden = root_r;
        state_nxt = S_NDIVW;
      end
      S_NDIVW: if (!dbusy) begin
        ua = dquo[31:0];
        ub = q_r[k_r[1:0]][31] ? -ua : ua;
        case (k_r)
          3'd0: res_nxt.out_a = ub;
          3'd1: res_nxt.out_b = ub;
          3'd2: res_nxt.out_c = ub;
          default: res_nxt.out_d = ub;
        endcase
        k_nxt = k_r + 3'd1;
        state_nxt = (k_r == 3'd3) ? S_OUT : S_NDIV;
      end
      S_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_ch.data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    it_r <= it_nxt; res_r <= res_nxt; n_r <= n_nxt; idx_r <= idx_nxt; k_r <= k_nxt;
    kn_r <= kn_nxt; pt_r <= pt_nxt; w_r <= w_nxt; q_r <= q_nxt; clamp_r <= clamp_nxt;
    acc_r <= acc_nxt; ra_r <= ra_nxt; root_r <= root_nxt; bit_r <= bit_nxt;
    x_r <= x_nxt; sh_r <= sh_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_r))
    else $error("result dropped");
  a_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken while result pending");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dstart |-> (state_r == S_DIV || state_r == S_NDIV)) else $error("stray divide");
endmodule

// ===== sv/spline_curve_evaluator.sv =====
// Top level: APB config registers and the evaluation core.
//  channel | dir | handshake      | payload
//  in_     | in  | valid/ready    | func, slot, time_value, comp_a..comp_d
//  out_    | out | valid/ready    | out_a..out_d, from_default, is_query
//  cfg_    | in  | APB write/read | curve_kind, rotation_mode, degree, fix_signs, knot_count
// Load: accept, then the ack beat. Query: a registered table read per knot scanned,
// the window read and the sign fix, up to three divides on the shared divider, then
// in rotation mode up to 30 pre-shifts and 32 root steps and four more divides.
// rst_n (synchronous) zeroes config, idles the core; the knot table is not cleared.
// One item at a time; in_ready is low until the result beat is taken.
module spline_curve_evaluator (
  input  logic                   clk,
  input  logic                   rst_n,
  sce_in_if.sink                 in_ch,
  sce_out_if.source              out_ch,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [sce_pkg::AddrW-1:0] cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);
  import sce_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_paddr)
        RegKind:   cfg_nxt.kind   = cfg_pwdata[1:0];
        RegRot:    cfg_nxt.rot    = cfg_pwdata[0];
        RegDegree: cfg_nxt.degree = cfg_pwdata[3:0];
        RegFix:    cfg_nxt.fix    = cfg_pwdata[0];
        RegCount:  cfg_nxt.count  = cfg_pwdata[CntW-1:0];
        default: ;
      endcase
    end
    case (cfg_paddr)
      RegKind:   cfg_prdata = {30'b0, cfg_r.kind};
      RegRot:    cfg_prdata = {31'b0, cfg_r.rot};
      RegDegree: cfg_prdata = {28'b0, cfg_r.degree};
      RegFix:    cfg_prdata = {31'b0, cfg_r.fix};
      RegCount:  cfg_prdata = {23'b0, cfg_r.count};
      default:   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else cfg_r <= cfg_nxt;
  end

  sce_core u_core (.clk, .rst_n, .cfg(cfg_r), .in_ch, .out_ch);
endmodule

// ===== test/spline_curve_evaluator_tb.sv =====
// Testbench: drives load and query beats into the spline curve evaluator and checks results.
`timescale 1ns / 100ps

module spline_curve_evaluator_tb;
  import sce_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int DrainWait  = 1500;
  localparam longint HalfQ  = 32768;

  typedef struct {
    bit                  is_cfg;
    logic [AddrW-1:0]    addr;
    int                  val;
    in_item_t            item;
    bit                  has_exp;
    out_item_t           exp;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [AddrW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  sce_in_if  in_if (clk);
  sce_out_if out_if (clk);

  spline_curve_evaluator uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // mirror of the block's registers and tables
  logic [1:0] kind_r;
  logic       rot_r, fix_r;
  int         deg_r, cnt_r;
  longint     knot_mem [MaxKnots];
  longint     pt_mem [MaxKnots][4];

  out_item_t  curve_q[$];
  stim_row_t  rows[$];
  int         errors, items_sent, results_seen, queries_sent;
  int         cycles = 0;
  bit         hold_req, quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint sat(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor((sum a*b + bias) / 2^16) without losing low bits
  function automatic longint sum_prod(longint a0, longint a1, longint a2, longint a3,
                                      longint b0, longint b1, longint b2, longint b3,
                                      longint bias);
    longint p[4];
    longint hi, lo, h;
    p[0] = a0 * b0; p[1] = a1 * b1; p[2] = a2 * b2; p[3] = a3 * b3;
    hi = 0;
    lo = bias;
    for (int i = 0; i < 4; i++) begin
      h = p[i] >>> 16;
      hi += h;
      lo += p[i] - (h <<< 16);
    end
    return hi + (lo >>> 16);
  endfunction

  function automatic longint mulq(longint a, longint b);
    return (a * b + HalfQ) >>> 16;
  endfunction

  function automatic longint ratio(longint num, longint den);
    if (den == 0) return 0;
    return sat((num * OneQ) / den);
  endfunction

  function automatic out_item_t predict_curve(in_item_t it);
    out_item_t o;
    longint t, u, v, s, b, dot;
    longint dv[4], res[4], kn[4], prev[4], w[3], q[4];
    longint pw[3][4];
    longint unsigned mag[4], sq, len, bt, r, x, nn;
    int n, idx, start, j, k;
    bit clamped;
    o = '0;
    t = it.time_value;
    dv[0] = it.comp_a; dv[1] = it.comp_b; dv[2] = it.comp_c; dv[3] = it.comp_d;
    if (it.func == FuncLoad) begin
      knot_mem[it.slot] = t;
      for (int i = 0; i < 4; i++) pt_mem[it.slot][i] = dv[i];
      return o;
    end
    o.is_query = 1'b1;
    n = (cnt_r > MaxKnots) ? MaxKnots : cnt_r;
    if (kind_r == KindIdentity || (kind_r >= KindStep && n == 0)) begin
      o.from_default = 1'b1;
      for (int i = 0; i < 4; i++) res[i] = dv[i];
    end else if (kind_r == KindConst) begin
      for (int i = 0; i < 4; i++) res[i] = pt_mem[0][rot_r ? (i + 3) % 4 : i];
    end else begin
      idx = 0;
      while (idx < n && knot_mem[idx] <= t) idx++;
      if (idx == n) idx--;
      if (kind_r == KindStep && !rot_r) begin
        for (int i = 0; i < 4; i++) res[i] = pt_mem[idx][i];
      end else begin
        start = idx - deg_r;
        clamped = (start < 0) || (idx + deg_r > n);
        for (int i = 0; i < 4; i++) begin
          j = start + i;
          if (j < 0) j = 0;
          if (j > n - 1) j = n - 1;
          kn[i] = knot_mem[j];
          if (i < 3)
            for (int c = 0; c < 4; c++) pw[i][c] = pt_mem[j][c];
        end
        if (rot_r && clamped && fix_r) begin
          for (int c = 0; c < 4; c++) prev[c] = 0;
          for (int i = 0; i < 3; i++) begin
            dot = sum_prod(pw[i][0], pw[i][1], pw[i][2], pw[i][3],
                           prev[0], prev[1], prev[2], prev[3], 0);
            if (dot < 0)
              for (int c = 0; c < 4; c++) pw[i][c] = sat(-pw[i][c]);
            for (int c = 0; c < 4; c++) prev[c] = pw[i][c];
          end
        end
        u = ratio(t - kn[0], kn[2] - kn[0]);
        v = ratio(t - kn[1], kn[2] - kn[1]);
        s = ratio(t - kn[1], kn[3] - kn[1]);
        b = sat(u + v - mulq(u, v));
        w[2] = sat(mulq(s, v));
        w[1] = sat(b - w[2]);
        w[0] = sat(OneQ - b);
        for (int c = 0; c < 4; c++)
          res[c] = sat(sum_prod(pw[0][c], pw[1][c], pw[2][c], 0, w[0], w[1], w[2], 0, HalfQ));
        if (rot_r) begin
          q[0] = res[3]; q[1] = res[0]; q[2] = res[1]; q[3] = res[2];
          // all four at the negative limit would overflow the square sum
          if (q[0] == -64'sd2147483648 && q[1] == q[0] && q[2] == q[0] && q[3] == q[0])
            for (int i = 0; i < 4; i++) q[i] = -1;
          sq = 0;
          for (int i = 0; i < 4; i++) begin
            mag[i] = (q[i] < 0) ? -q[i] : q[i];
            sq += mag[i] * mag[i];
          end
          if (sq != 0) begin
            k = 0;
            while (sq < (64'd1 << 60)) begin
              sq = sq << 2;
              k++;
            end
            x = sq;
            r = 0;
            bt = 64'd1 << 62;
            while (bt > x) bt = bt >> 2;
            while (bt != 0) begin
              if (x >= r + bt) begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
              end else begin
                r = r >> 1;
              end
              bt = bt >> 2;
            end
            len = r;
            for (int i = 0; i < 4; i++) begin
              nn = ((mag[i] << k) << 16) + len / 2;
              q[i] = (q[i] < 0) ? -longint'(nn / len) : longint'(nn / len);
            end
          end
          for (int i = 0; i < 4; i++) res[i] = q[i];
        end
      end
    end
    o.out_a = res[0][31:0];
    o.out_b = res[1][31:0];
    o.out_c = res[2][31:0];
    o.out_d = res[3][31:0];
    return o;
  endfunction

  function automatic void cmp_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endfunction

  // result side: compare each taken beat with the oldest expectation
  always @(posedge clk) begin
    out_item_t e, a;
    if (rst_n && out_if.valid && out_if.ready) begin
      a = out_if.data;
      if (curve_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = curve_q.pop_front();
        results_seen++;
        cmp_field("out_a", e.out_a, a.out_a);
        cmp_field("out_b", e.out_b, a.out_b);
        cmp_field("out_c", e.out_c, a.out_c);
        cmp_field("out_d", e.out_d, a.out_d);
        cmp_field("from_default", e.from_default, a.from_default);
        cmp_field("is_query", e.is_query, a.is_query);
      end
    end
  end

  // result ready: random stalls, one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(in_item_t it, bit has_exp, out_item_t exp);
    out_item_t p;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    p = predict_curve(it);
    curve_q.insert(curve_q.size(), has_exp ? exp : p);
    items_sent++;
    if (it.func == FuncQuery) queries_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    wait (curve_q.size() == 0);
  endtask

  task automatic cfg_write(logic [AddrW-1:0] addr, int val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (addr)
      RegKind:   kind_r = val[1:0];
      RegRot:    rot_r  = val[0];
      RegDegree: deg_r  = int'(val[3:0]);
      RegFix:    fix_r  = val[0];
      RegCount:  cnt_r  = int'(val[8:0]);
      default: ;
    endcase
  endtask

  function automatic in_item_t mk_item(logic func, int slot, int t, int a, int b, int c, int d);
    in_item_t it;
    it.func = func; it.slot = slot[7:0]; it.time_value = t;
    it.comp_a = a; it.comp_b = b; it.comp_c = c; it.comp_d = d;
    return it;
  endfunction

  function automatic void add_item(in_item_t it, bit has_exp, out_item_t exp);
    stim_row_t r;
    r.is_cfg = 1'b0; r.addr = '0; r.val = 0;
    r.item = it; r.has_exp = has_exp; r.exp = exp;
    rows.insert(rows.size(), r);
  endfunction

  function automatic void add_cfg(logic [AddrW-1:0] addr, int val);
    stim_row_t r;
    r.is_cfg = 1'b1; r.addr = addr; r.val = val;
    r.item = '0; r.has_exp = 1'b0; r.exp = '0;
    rows.insert(rows.size(), r);
  endfunction

  function automatic out_item_t mk_res(int a, int b, int c, int d, logic dflt);
    out_item_t o;
    o.out_a = a; o.out_b = b; o.out_c = c; o.out_d = d;
    o.from_default = dflt; o.is_query = 1'b1;
    return o;
  endfunction

  function automatic int rnd_comp();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return int'($urandom_range(0, 32'h40000)) - 32'h20000;
  endfunction

  initial begin
    out_item_t ack, none;
    int n, step, base, nq, phase, knot_hi, t;
    ack = '0;
    none = '0;
    errors = 0; items_sent = 0; results_seen = 0; queries_sent = 0;
    hold_req = 1'b0; quiet = 1'b0;
    kind_r = KindIdentity; rot_r = 1'b0; fix_r = 1'b0; deg_r = 0; cnt_r = 0;
    for (int i = 0; i < MaxKnots; i++) begin
      knot_mem[i] = 0;
      for (int c = 0; c < 4; c++) pt_mem[i][c] = 0;
    end
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: loads at the extremes, then each kind and special case
    add_item(mk_item(FuncLoad, 0, 0, 32'h10000, 32'h20000, 32'h30000, 32'h40000), 1, ack);
    add_item(mk_item(FuncLoad, 1, 32'h10000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff), 1, ack);
    add_item(mk_item(FuncLoad, 2, 32'h20000, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000), 1, ack);
    add_item(mk_item(FuncLoad, 3, 32'h30000, 0, 0, 0, 0), 1, ack);
    add_item(mk_item(FuncLoad, 255, 32'h7fffffff, 32'h80000000, -1, 1, 32'h7fffffff), 1, ack);
    add_item(mk_item(FuncQuery, 255, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, -1), 1,
             mk_res(32'h80000000, 32'h7fffffff, 0, -1, 1'b1));
    add_cfg(RegKind, int'(KindStep));
    add_item(mk_item(FuncQuery, 0, 5, 7, 8, 9, 10), 1, mk_res(7, 8, 9, 10, 1'b1));
    add_cfg(RegKind, int'(KindInterp));
    add_item(mk_item(FuncQuery, 0, 5, 1, 2, 3, 4), 1, mk_res(1, 2, 3, 4, 1'b1));
    add_cfg(RegCount, 4);
    add_cfg(RegKind, int'(KindConst));
    add_item(mk_item(FuncQuery, 0, 0, 0, 0, 0, 0), 1,
             mk_res(32'h10000, 32'h20000, 32'h30000, 32'h40000, 1'b0));
    add_cfg(RegRot, 1);
    add_item(mk_item(FuncQuery, 0, 0, 0, 0, 0, 0), 1,
             mk_res(32'h40000, 32'h10000, 32'h20000, 32'h30000, 1'b0));
    add_cfg(RegKind, int'(KindStep));
    add_item(mk_item(FuncQuery, 0, 32'h8000, 0, 0, 0, 0), 0, none);
    // weights of 2 on point 2 saturate every component to the negative limit
    add_item(mk_item(FuncQuery, 0, 32'h10000, 0, 0, 0, 0), 0, none);
    add_item(mk_item(FuncQuery, 0, 32'h40000, 0, 0, 0, 0), 0, none);
    add_cfg(RegRot, 0);
    add_item(mk_item(FuncQuery, 0, 32'h18000, 0, 0, 0, 0), 0, none);
    add_cfg(RegKind, int'(KindInterp));
    add_item(mk_item(FuncQuery, 0, 32'h8000, 0, 0, 0, 0), 0, none);
    add_cfg(RegDegree, 15);
    add_item(mk_item(FuncQuery, 0, 32'h28000, 0, 0, 0, 0), 0, none);
    add_cfg(RegRot, 1);
    add_cfg(RegFix, 1);
    add_cfg(RegDegree, 2);
    add_item(mk_item(FuncQuery, 0, 32'h8000, 0, 0, 0, 0), 0, none);
    add_item(mk_item(FuncQuery, 0, 32'h7fffffff, 0, 0, 0, 0), 0, none);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        cfg_write(rows[i].addr, rows[i].val);
      end else begin
        send_item(rows[i].item, rows[i].has_exp, rows[i].exp);
      end
    end

    // random phases: fresh config, sorted table load, then mostly queries
    phase = 0;
    while (items_sent < 600) begin
      drain();
      case ($urandom_range(0, 9))
        0: n = 0;
        1: n = $urandom_range(13, 40);
        default: n = $urandom_range(1, 12);
      endcase
      if (phase == 2) n = MaxKnots;
      cfg_write(RegKind, $urandom_range(0, 9) < 6 ? int'(KindInterp)
                                                  : int'($urandom_range(0, 3)));
      cfg_write(RegRot, $urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: cfg_write(RegDegree, 0);
        1: cfg_write(RegDegree, 15);
        default: cfg_write(RegDegree, $urandom_range(0, 4));
      endcase
      cfg_write(RegFix, $urandom_range(0, 1));
      cfg_write(RegCount, n);
      if (items_sent >= 540) quiet = 1'b1;
      step = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 32'h30000);
      base = int'($urandom_range(0, 32'h80000)) - 32'h40000;
      for (int i = 0; i < n; i++) begin
        // equal neighbors now and then give zero denominators
        t = base + i * step + (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, step / 2));
        send_item(mk_item(FuncLoad, i, t, rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp()), 0,
                  none);
      end
      knot_hi = base + n * step + step;
      if (phase == 1) hold_req = 1'b1;
      nq = $urandom_range(8, 20);
      for (int i = 0; i < nq; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray load anywhere; the table stays fully written
          send_item(mk_item(FuncLoad, $urandom_range(0, 255), $urandom, $urandom, $urandom,
                            $urandom, $urandom), 0, none);
        end else begin
          if ($urandom_range(0, 7) == 0) t = $urandom;
          else t = base - step + int'($urandom_range(0, knot_hi - base + step));
          send_item(mk_item(FuncQuery, $urandom_range(0, 255), t, $urandom, $urandom,
                            $urandom, $urandom), 0, none);
        end
      end
      phase++;
    end

    drain();
    repeat (DrainWait) @(posedge clk);
    $display("Sent %0d beats (%0d queries) over %0d config phases; %0d results checked.",
             items_sent, queries_sent, phase, results_seen);
    if (errors == 0 && curve_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sce_pkg.sv
sv/sce_if.sv
sv/sce_div.sv
sv/sce_core.sv
sv/spline_curve_evaluator.sv
test/spline_curve_evaluator_tb.sv
